### rtl/core/ltep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltep_pkg
// Shared types, constants and small lookups for the log time to epoch parser.
// ----------------------------------------------------------------------------
package ltep_pkg;

   // status codes carried with each result
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_LENGTH = 3'd1;
   localparam logic [2:0] ST_MONTH  = 3'd2;
   localparam logic [2:0] ST_DIGIT  = 3'd3;
   localparam logic [2:0] ST_ZONE   = 3'd4;

   // characters of the timestamp syntax
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // calendar constants
   localparam int unsigned YEAR_BASE         = 1970;
   localparam int unsigned LEAPS_BEFORE_BASE = 477;    // leap days in years 1..1969
   localparam int unsigned DAYS_PER_YEAR     = 365;
   localparam int unsigned SECS_PER_DAY      = 86400;
   localparam int unsigned SECS_PER_HOUR     = 3600;
   localparam int unsigned SECS_PER_MIN      = 60;

   // reciprocal of 25, exact for dividends below 2500
   localparam int unsigned RECIP_25    = 5243;
   localparam int unsigned RECIP_SHIFT = 17;

   // default queue depths
   localparam int unsigned JOB_DEPTH_DEFAULT = 4;
   localparam int unsigned RSP_DEPTH_DEFAULT = 8;

   // month abbreviations, case sensitive
   localparam logic [23:0] MONTH_NAMES [12] = '{
      "Jan", "Feb", "Mar", "Apr", "May", "Jun",
      "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"
   };

   // days in the year before the first of each month, non-leap
   localparam logic [8:0] DAYS_BEFORE [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   // parsed timestamp handed from the front end to the back end
   typedef struct packed {
      logic [2:0]  status;
      logic [13:0] year;
      logic [3:0]  month;
      logic [6:0]  day;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic        zone_plus;
      logic [6:0]  zone_hours;
      logic [6:0]  zone_minutes;
   } job_type;

   // finished result waiting in the output queue
   typedef struct packed {
      logic [63:0] epoch_seconds;
      logic [2:0]  status;
   } result_type;

   // month number 1..12 for three letters, 0 when nothing matches
   function automatic logic [3:0] month_number(input logic [23:0] letters);
      logic [3:0] num;
      num = 4'd0;
      for (int i = 11; i >= 0; i--) begin
         if (letters == MONTH_NAMES[i]) begin
            num = 4'(i + 1);
         end
      end
      return num;
   endfunction

endpackage

### rtl/core/ltep_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltep_front
// Character parser: walks the 26 byte timestamp, collects the fields and
// the first error, and emits one parsed job on the last byte.
// ----------------------------------------------------------------------------
module ltep_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         char_byte,
   input  logic               last_char,
   output logic               job_push,
   output ltep_pkg::job_type  job
);

   // character positions within the text
   localparam logic [4:0] POS_DAY_HI    = 5'd0;
   localparam logic [4:0] POS_DAY_LO    = 5'd1;
   localparam logic [4:0] POS_DAY_SEP   = 5'd2;
   localparam logic [4:0] POS_MON_A     = 5'd3;
   localparam logic [4:0] POS_MON_B     = 5'd4;
   localparam logic [4:0] POS_MON_C     = 5'd5;
   localparam logic [4:0] POS_MON_SEP   = 5'd6;
   localparam logic [4:0] POS_YEAR_0    = 5'd7;
   localparam logic [4:0] POS_YEAR_1    = 5'd8;
   localparam logic [4:0] POS_YEAR_2    = 5'd9;
   localparam logic [4:0] POS_YEAR_3    = 5'd10;
   localparam logic [4:0] POS_YEAR_SEP  = 5'd11;
   localparam logic [4:0] POS_HOUR_HI   = 5'd12;
   localparam logic [4:0] POS_HOUR_LO   = 5'd13;
   localparam logic [4:0] POS_HOUR_SEP  = 5'd14;
   localparam logic [4:0] POS_MIN_HI    = 5'd15;
   localparam logic [4:0] POS_MIN_LO    = 5'd16;
   localparam logic [4:0] POS_MIN_SEP   = 5'd17;
   localparam logic [4:0] POS_SEC_HI    = 5'd18;
   localparam logic [4:0] POS_SEC_LO    = 5'd19;
   localparam logic [4:0] POS_SEC_SEP   = 5'd20;
   localparam logic [4:0] POS_ZONE_SIGN = 5'd21;
   localparam logic [4:0] POS_ZH_HI     = 5'd22;
   localparam logic [4:0] POS_ZH_LO     = 5'd23;
   localparam logic [4:0] POS_ZM_HI     = 5'd24;
   localparam logic [4:0] POS_ZM_LO     = 5'd25;
   localparam logic [4:0] TEXT_LEN      = 5'd26;
   localparam logic [4:0] POS_LIMIT     = 5'd27;

   logic [4:0]  pos_ff, pos_in;
   logic [6:0]  day_ff, day_in;
   logic [15:0] mon_letters_ff, mon_letters_in;
   logic [3:0]  month_ff, month_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;
   logic        zone_plus_ff, zone_plus_in;
   logic [6:0]  zone_hours_ff, zone_hours_in;
   logic [6:0]  zone_minutes_ff, zone_minutes_in;
   logic [2:0]  error_ff, error_in;
   logic        field_bad_ff, field_bad_in;
   logic [2:0]  zone_error_ff, zone_error_in;

   logic        is_digit;
   logic [3:0]  digit;
   logic [2:0]  final_status;

   assign is_digit = (char_byte >= ltep_pkg::CHAR_ZERO) && (char_byte <= ltep_pkg::CHAR_NINE);
   assign digit    = 4'(char_byte - ltep_pkg::CHAR_ZERO);

   // field separator check, first error wins
   function automatic logic [2:0] sep_check(input logic [2:0] err, input logic [7:0] ch,
                                             input logic [7:0] sep, input logic bad);
      logic [2:0] res;
      res = err;
      if (err == ltep_pkg::ST_OK) begin
         if (ch != sep) begin
            res = ltep_pkg::ST_LENGTH;
         end else if (bad) begin
            res = ltep_pkg::ST_DIGIT;
         end
      end
      return res;
   endfunction

   // per-position field update
   always_comb begin
      pos_in          = pos_ff;
      day_in          = day_ff;
      mon_letters_in  = mon_letters_ff;
      month_in        = month_ff;
      year_in         = year_ff;
      hour_in         = hour_ff;
      minute_in       = minute_ff;
      second_in       = second_ff;
      zone_plus_in    = zone_plus_ff;
      zone_hours_in   = zone_hours_ff;
      zone_minutes_in = zone_minutes_ff;
      error_in        = error_ff;
      field_bad_in    = field_bad_ff;
      zone_error_in   = zone_error_ff;
      case (pos_ff)
         POS_DAY_HI, POS_DAY_LO: begin
            if (is_digit) day_in = 7'(8'(day_ff) * 8'd10 + 8'(digit));
            else field_bad_in = 1'b1;
         end
         POS_DAY_SEP: begin
            error_in = sep_check(error_ff, char_byte, ltep_pkg::CHAR_SLASH, field_bad_ff);
            field_bad_in = 1'b0;
         end
         POS_MON_A: begin
            mon_letters_in = {char_byte, 8'h00};
         end
         POS_MON_B: begin
            mon_letters_in = {mon_letters_ff[15:8], char_byte};
         end
         POS_MON_C: begin
            month_in = ltep_pkg::month_number({mon_letters_ff, char_byte});
         end
         POS_MON_SEP: begin
            if (error_ff == ltep_pkg::ST_OK) begin
               if (char_byte != ltep_pkg::CHAR_SLASH) error_in = ltep_pkg::ST_LENGTH;
               else if (month_ff == 4'd0) error_in = ltep_pkg::ST_MONTH;
            end
            field_bad_in = 1'b0;
         end
         POS_YEAR_0, POS_YEAR_1, POS_YEAR_2, POS_YEAR_3: begin
            if (is_digit) year_in = 14'(18'(year_ff) * 18'd10 + 18'(digit));
            else field_bad_in = 1'b1;
         end
         POS_YEAR_SEP, POS_HOUR_SEP, POS_MIN_SEP: begin
            error_in = sep_check(error_ff, char_byte, ltep_pkg::CHAR_COLON, field_bad_ff);
            field_bad_in = 1'b0;
         end
         POS_HOUR_HI, POS_HOUR_LO: begin
            if (is_digit) hour_in = 7'(8'(hour_ff) * 8'd10 + 8'(digit));
            else field_bad_in = 1'b1;
         end
         POS_MIN_HI, POS_MIN_LO: begin
            if (is_digit) minute_in = 7'(8'(minute_ff) * 8'd10 + 8'(digit));
            else field_bad_in = 1'b1;
         end
         POS_SEC_HI, POS_SEC_LO: begin
            if (is_digit) second_in = 7'(8'(second_ff) * 8'd10 + 8'(digit));
            else field_bad_in = 1'b1;
         end
         POS_SEC_SEP: begin
            error_in = sep_check(error_ff, char_byte, ltep_pkg::CHAR_SPACE, field_bad_ff);
            field_bad_in = 1'b0;
         end
         POS_ZONE_SIGN: begin
            zone_plus_in = (char_byte == ltep_pkg::CHAR_PLUS);
            if ((char_byte != ltep_pkg::CHAR_PLUS) && (char_byte != ltep_pkg::CHAR_MINUS) &&
                (zone_error_ff == ltep_pkg::ST_OK)) begin
               zone_error_in = ltep_pkg::ST_ZONE;
            end
         end
         POS_ZH_HI, POS_ZH_LO: begin
            if (is_digit) zone_hours_in = 7'(8'(zone_hours_ff) * 8'd10 + 8'(digit));
            else if (zone_error_ff == ltep_pkg::ST_OK) zone_error_in = ltep_pkg::ST_DIGIT;
         end
         POS_ZM_HI, POS_ZM_LO: begin
            if (is_digit) zone_minutes_in = 7'(8'(zone_minutes_ff) * 8'd10 + 8'(digit));
            else if (zone_error_ff == ltep_pkg::ST_OK) zone_error_in = ltep_pkg::ST_DIGIT;
         end
         default: begin
         end
      endcase
      // position saturates past the end of the text
      if (pos_ff < POS_LIMIT) pos_in = pos_ff + 5'd1;
   end

   // final status in check order: fields, length, zone
   always_comb begin
      final_status = error_in;
      if ((final_status == ltep_pkg::ST_OK) && (pos_in != TEXT_LEN)) begin
         final_status = ltep_pkg::ST_LENGTH;
      end
      if (final_status == ltep_pkg::ST_OK) begin
         final_status = zone_error_in;
      end
   end

   // job handed to the queue on the last byte
   assign job_push          = accept && last_char;
   assign job.status        = final_status;
   assign job.year          = year_in;
   assign job.month         = month_in;
   assign job.day           = day_in;
   assign job.hour          = hour_in;
   assign job.minute        = minute_in;
   assign job.second        = second_in;
   assign job.zone_plus     = zone_plus_in;
   assign job.zone_hours    = zone_hours_in;
   assign job.zone_minutes  = zone_minutes_in;

   // parser state, cleared after each timestamp
   always_ff @(posedge clock) begin
      if (reset || (accept && last_char)) begin
         pos_ff          <= '0;
         day_ff          <= '0;
         mon_letters_ff  <= '0;
         month_ff        <= '0;
         year_ff         <= '0;
         hour_ff         <= '0;
         minute_ff       <= '0;
         second_ff       <= '0;
         zone_plus_ff    <= 1'b0;
         zone_hours_ff   <= '0;
         zone_minutes_ff <= '0;
         error_ff        <= ltep_pkg::ST_OK;
         field_bad_ff    <= 1'b0;
         zone_error_ff   <= ltep_pkg::ST_OK;
      end else if (accept) begin
         pos_ff          <= pos_in;
         day_ff          <= day_in;
         mon_letters_ff  <= mon_letters_in;
         month_ff        <= month_in;
         year_ff         <= year_in;
         hour_ff         <= hour_in;
         minute_ff       <= minute_in;
         second_ff       <= second_in;
         zone_plus_ff    <= zone_plus_in;
         zone_hours_ff   <= zone_hours_in;
         zone_minutes_ff <= zone_minutes_in;
         error_ff        <= error_in;
         field_bad_ff    <= field_bad_in;
         zone_error_ff   <= zone_error_in;
      end
   end

endmodule

### rtl/core/ltep_job_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltep_job_queue
// Small queue of parsed jobs between the parser and the arithmetic back end.
// ----------------------------------------------------------------------------
module ltep_job_queue #(
   parameter int unsigned DEPTH = ltep_pkg::JOB_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ltep_pkg::job_type  push_job,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output ltep_pkg::job_type  head_job
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ltep_pkg::job_type mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = mem[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ptr_ff] <= push_job;
   end

endmodule

### rtl/core/ltep_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltep_back
// Epoch arithmetic: three stage pipeline from parsed fields to seconds since
// 1970, feeding a result queue. Jobs are issued only against free queue room.
// ----------------------------------------------------------------------------
module ltep_back #(
   parameter int unsigned RSP_DEPTH = ltep_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_empty,
   input  ltep_pkg::job_type  job,
   output logic               job_pop,
   output logic [63:0]        epoch_seconds,
   output logic [2:0]         status,
   output logic               empty,
   input  logic               pop
);

   localparam int unsigned PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(RSP_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RSP_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RSP_DEPTH);

   // quotient by 25 through the reciprocal, valid below 2500
   function automatic logic [6:0] div25(input logic [11:0] val);
      logic [24:0] prod;
      prod = 25'(val) * 25'(ltep_pkg::RECIP_25);
      return prod[ltep_pkg::RECIP_SHIFT +: 7];
   endfunction

   logic             issue;
   logic             pop_ok;
   logic [CNT_W-1:0] occ_ff, occ_in;

   // stage 1: century quotients and zone shift
   logic        s1_valid_ff;
   logic [2:0]  s1_status_ff;
   logic [13:0] s1_year_ff;
   logic [3:0]  s1_month_ff;
   logic [6:0]  s1_day_ff, s1_hour_ff, s1_minute_ff, s1_second_ff;
   logic        s1_plus_ff;
   logic [18:0] s1_shift_ff;
   logic [6:0]  s1_q100_ff, s1_q400_ff, s1_q100m_ff, s1_q400m_ff;
   logic [13:0] year_m1;

   // stage 2: day count and time of day
   logic        s2_valid_ff;
   logic [2:0]  s2_status_ff;
   logic [21:0] s2_days_ff, s2_days_in;
   logic [23:0] s2_tod_ff, s2_tod_in;
   logic        s2_plus_ff;
   logic [18:0] s2_shift_ff;
   logic        leap;
   logic [13:0] s1_year_m1;

   // stage 3: days to seconds
   logic        s3_valid_ff;
   logic [2:0]  s3_status_ff;
   logic [38:0] s3_daysec_ff;
   logic [23:0] s3_tod_ff;
   logic        s3_plus_ff;
   logic [18:0] s3_shift_ff;

   // result queue
   ltep_pkg::result_type mem [RSP_DEPTH];
   ltep_pkg::result_type wr_result;
   logic [63:0]          base_sec;
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff, count_in;

   // issue against queue room counting items still in the pipeline
   assign issue   = !job_empty && (occ_ff < FULL_CNT);
   assign job_pop = issue;
   assign pop_ok  = pop && !empty;

   always_comb begin
      occ_in = occ_ff;
      if (issue && !pop_ok) occ_in = occ_ff + CNT_W'(1);
      else if (pop_ok && !issue) occ_in = occ_ff - CNT_W'(1);
   end

   assign year_m1 = job.year - 14'd1;

   // stage 1 registers
   always_ff @(posedge clock) begin
      s1_status_ff <= job.status;
      s1_year_ff   <= job.year;
      s1_month_ff  <= job.month;
      s1_day_ff    <= job.day;
      s1_hour_ff   <= job.hour;
      s1_minute_ff <= job.minute;
      s1_second_ff <= job.second;
      s1_plus_ff   <= job.zone_plus;
      s1_shift_ff  <= 19'(19'(job.zone_hours) * 19'(ltep_pkg::SECS_PER_HOUR)
                        + 19'(job.zone_minutes) * 19'(ltep_pkg::SECS_PER_MIN));
      s1_q100_ff   <= div25(job.year[13:2]);
      s1_q400_ff   <= div25({2'b00, job.year[13:4]});
      s1_q100m_ff  <= div25(year_m1[13:2]);
      s1_q400m_ff  <= div25({2'b00, year_m1[13:4]});
   end

   // stage 2 logic: whole years, months, and seconds within the day count
   assign s1_year_m1 = s1_year_ff - 14'd1;
   assign leap = ((s1_year_ff[1:0] == 2'b00) && (s1_year_ff != 14'(s1_q100_ff * 14'd100))) ||
                 (s1_year_ff == 14'(s1_q400_ff * 14'd400));

   always_comb begin
      s2_days_in = '0;
      if (s1_year_ff > 14'(ltep_pkg::YEAR_BASE)) begin
         s2_days_in = 22'(s1_year_ff - 14'(ltep_pkg::YEAR_BASE)) * 22'(ltep_pkg::DAYS_PER_YEAR)
                    + 22'(s1_year_m1[13:2]) - 22'(s1_q100m_ff) + 22'(s1_q400m_ff)
                    - 22'(ltep_pkg::LEAPS_BEFORE_BASE);
      end
      if ((s1_month_ff >= 4'd1) && (s1_month_ff <= 4'd12)) begin
         s2_days_in = s2_days_in + 22'(ltep_pkg::DAYS_BEFORE[s1_month_ff - 4'd1]);
         if ((s1_month_ff > 4'd2) && leap) s2_days_in = s2_days_in + 22'd1;
      end
      s2_tod_in = 24'(s1_day_ff) * 24'(ltep_pkg::SECS_PER_DAY)
                + 24'(s1_hour_ff) * 24'(ltep_pkg::SECS_PER_HOUR)
                + 24'(s1_minute_ff) * 24'(ltep_pkg::SECS_PER_MIN)
                + 24'(s1_second_ff);
   end

   always_ff @(posedge clock) begin
      s2_status_ff <= s1_status_ff;
      s2_days_ff   <= s2_days_in;
      s2_tod_ff    <= s2_tod_in;
      s2_plus_ff   <= s1_plus_ff;
      s2_shift_ff  <= s1_shift_ff;
   end

   // stage 3 registers
   always_ff @(posedge clock) begin
      s3_status_ff <= s2_status_ff;
      s3_daysec_ff <= 39'(s2_days_ff) * 39'(ltep_pkg::SECS_PER_DAY);
      s3_tod_ff    <= s2_tod_ff;
      s3_plus_ff   <= s2_plus_ff;
      s3_shift_ff  <= s2_shift_ff;
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         occ_ff      <= '0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         occ_ff      <= occ_in;
      end
   end

   // final sum with day minus one and the zone shift, wrapping at 64 bits
   assign base_sec = 64'(s3_daysec_ff) + 64'(s3_tod_ff) - 64'(ltep_pkg::SECS_PER_DAY);
   always_comb begin
      wr_result.status = s3_status_ff;
      if (s3_status_ff != ltep_pkg::ST_OK) wr_result.epoch_seconds = '0;
      else if (s3_plus_ff) wr_result.epoch_seconds = base_sec - 64'(s3_shift_ff);
      else wr_result.epoch_seconds = base_sec + 64'(s3_shift_ff);
   end

   // result queue control
   always_comb begin
      count_in = count_ff;
      if (s3_valid_ff && !pop_ok) count_in = count_ff + CNT_W'(1);
      else if (pop_ok && !s3_valid_ff) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (s3_valid_ff) wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         if (pop_ok)      rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff) mem[wr_ptr_ff] <= wr_result;
   end

   assign empty         = (count_ff == '0);
   assign epoch_seconds = mem[rd_ptr_ff].epoch_seconds;
   assign status        = mem[rd_ptr_ff].status;

   // checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL_CNT)
      else $error("result credit count exceeds queue depth");

   a_queue_within_credit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= occ_ff)
      else $error("result queue holds more items than were issued");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && (status != ltep_pkg::ST_OK)) |-> (epoch_seconds == 64'd0))
      else $error("error result carries nonzero seconds");

   a_issue_reaches_queue: assert property (@(posedge clock) disable iff (reset)
      issue |=> ##2 s3_valid_ff)
      else $error("issued job did not reach the result stage");

endmodule

### rtl/core/log_time_to_epoch_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_time_to_epoch_parser
// Parses "dd/Mon/yyyy:hh:mm:ss +hhmm" one byte at a time and returns the
// seconds since 1970 with a status code for each timestamp.
// ----------------------------------------------------------------------------
//  channel   ports                                    handshake
//  request   req_char_byte, req_last_char             push / full
//  response  rsp_epoch_seconds, rsp_status            pop / empty
//
//  One byte is taken every cycle while full is low.
//  A timestamp's last byte goes into the job queue, then through three
//  arithmetic stages, then into the result queue that drives the output.
//  Synchronous reset clears parser state and both queues.
//  full rises only while the job queue holds JOB_DEPTH timestamps; the back
//  end stops taking jobs once in-flight plus queued results reach RSP_DEPTH.
// ----------------------------------------------------------------------------
module log_time_to_epoch_parser #(
   parameter int unsigned JOB_DEPTH = ltep_pkg::JOB_DEPTH_DEFAULT,
   parameter int unsigned RSP_DEPTH = ltep_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_char_byte,
   input  logic        req_last_char,
   input  logic        push,
   output logic        full,
   output logic [63:0] rsp_epoch_seconds,
   output logic [2:0]  rsp_status,
   output logic        empty,
   input  logic        pop
);

   logic              accept;
   logic              job_push;
   ltep_pkg::job_type new_job;
   ltep_pkg::job_type head_job;
   logic              job_empty;
   logic              job_pop;

   assign accept = push && !full;

   // byte parser
   ltep_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_byte (req_char_byte),
      .last_char (req_last_char),
      .job_push  (job_push),
      .job       (new_job)
   );

   // parsed job queue
   ltep_job_queue #(
      .DEPTH (JOB_DEPTH)
   ) u_job_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (new_job),
      .full     (full),
      .pop      (job_pop),
      .empty    (job_empty),
      .head_job (head_job)
   );

   // epoch arithmetic and result queue
   ltep_back #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_empty     (job_empty),
      .job           (head_job),
      .job_pop       (job_pop),
      .epoch_seconds (rsp_epoch_seconds),
      .status        (rsp_status),
      .empty         (empty),
      .pop           (pop)
   );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams timestamp text into log_time_to_epoch_parser one character per
// handshake and checks every epoch and status against a predictor that
// parses the same characters. Covers directed values, format errors, random
// traffic under three idle patterns and a long result-side stall.
// ----------------------------------------------------------------------------
module testbench;

   typedef logic [7:0] char_list_type[$];

   localparam int STAMP_LEN       = 26;
   localparam int HOLD_CYCLES     = 400;
   localparam int STALL_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int RANDOM_STAMPS   = 5;
   localparam int PRESSURE_STAMPS = 16;

   localparam logic [23:0] MONTH_TEXT [12] = '{
      "Jan", "Feb", "Mar", "Apr", "May", "Jun",
      "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"
   };
   localparam int unsigned MONTH_START_DAY [12] = '{
      0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
   };
   localparam int SEPARATOR_POS [6] = '{2, 6, 11, 14, 17, 20};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [7:0]  req_char_byte = 8'd0;
   logic        req_last_char = 1'b0;
   logic        push = 1'b0;
   logic        full;
   logic [63:0] rsp_epoch_seconds;
   logic [2:0]  rsp_status;
   logic        empty;
   logic        pop = 1'b0;

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   bit hold_request  = 1'b0;
   int hold_left     = 0;
   int stall_cycles  = 0;
   int error_count   = 0;

   ltep_pkg::result_type expected_epochs[$];

   // parser state mirrored by the predictor
   logic [4:0]  char_count       = '0;
   logic [7:0]  day_acc          = '0;
   logic [15:0] month_pair       = '0;
   logic [3:0]  month_num        = '0;
   logic [15:0] year_acc         = '0;
   logic [7:0]  hour_acc         = '0;
   logic [7:0]  minute_acc       = '0;
   logic [7:0]  second_acc       = '0;
   logic        zone_plus        = 1'b0;
   logic [7:0]  zone_hr          = '0;
   logic [7:0]  zone_min         = '0;
   logic [2:0]  first_error      = ltep_pkg::ST_OK;
   logic        field_has_bad    = 1'b0;
   logic [2:0]  zone_first_error = ltep_pkg::ST_OK;

   log_time_to_epoch_parser DUT (
      .clock             (clock),
      .reset             (reset),
      .req_char_byte     (req_char_byte),
      .req_last_char     (req_last_char),
      .push              (push),
      .full              (full),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .rsp_status        (rsp_status),
      .empty             (empty),
      .pop               (pop)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit is_digit(input logic [7:0] ch);
      return ch >= ltep_pkg::CHAR_ZERO && ch <= ltep_pkg::CHAR_NINE;
   endfunction

   function automatic bit is_leap(input longint unsigned yr);
      return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
   endfunction

   function automatic longint unsigned leap_days_through(input longint unsigned n);
      return n / 4 - n / 100 + n / 400;
   endfunction

   function automatic void clear_parse_state();
      char_count = '0;
      day_acc = '0;
      month_pair = '0;
      month_num = '0;
      year_acc = '0;
      hour_acc = '0;
      minute_acc = '0;
      second_acc = '0;
      zone_plus = 1'b0;
      zone_hr = '0;
      zone_min = '0;
      first_error = ltep_pkg::ST_OK;
      field_has_bad = 1'b0;
      zone_first_error = ltep_pkg::ST_OK;
   endfunction

   // separator after a numeric field, first error wins
   function automatic void close_field(input logic [7:0] ch, input logic [7:0] sep);
      if (first_error == ltep_pkg::ST_OK) begin
         if (ch != sep) first_error = ltep_pkg::ST_LENGTH;
         else if (field_has_bad) first_error = ltep_pkg::ST_DIGIT;
      end
      field_has_bad = 1'b0;
   endfunction

   // seconds since 1970 from the parsed fields, wrapping at 64 bits
   function automatic logic [63:0] epoch_from_fields();
      longint unsigned yr;
      longint unsigned days;
      longint unsigned secs;
      longint unsigned shift;
      yr = longint'(year_acc);
      days = 0;
      if (yr > 1970)
         days = 365 * (yr - 1970) + leap_days_through(yr - 1) - leap_days_through(1969);
      if (month_num >= 1 && month_num <= 12) begin
         days += MONTH_START_DAY[month_num - 1];
         if (month_num > 2 && is_leap(yr)) days += 1;
      end
      secs = days * 64'd86400;
      secs += (longint'(day_acc) - 64'd1) * 64'd86400;
      secs += longint'(hour_acc) * 64'd3600;
      secs += longint'(minute_acc) * 64'd60;
      secs += longint'(second_acc);
      shift = longint'(zone_hr) * 64'd3600 + longint'(zone_min) * 64'd60;
      return zone_plus ? secs - shift : secs + shift;
   endfunction

   // advance the predictor by one accepted character
   function automatic void parse_char(input logic [7:0] ch, input logic last);
      logic [2:0] verdict;
      ltep_pkg::result_type outcome;
      case (char_count)
         5'd0, 5'd1: begin
            if (is_digit(ch)) day_acc = day_acc * 8'd10 + (ch - ltep_pkg::CHAR_ZERO);
            else field_has_bad = 1'b1;
         end
         5'd2: close_field(ch, ltep_pkg::CHAR_SLASH);
         5'd3: month_pair = {ch, 8'h00};
         5'd4: month_pair[7:0] = ch;
         5'd5: begin
            month_num = '0;
            for (int i = 11; i >= 0; i--) begin
               if ({month_pair, ch} == MONTH_TEXT[i]) month_num = 4'(i + 1);
            end
         end
         5'd6: begin
            if (first_error == ltep_pkg::ST_OK) begin
               if (ch != ltep_pkg::CHAR_SLASH) first_error = ltep_pkg::ST_LENGTH;
               else if (month_num == 0) first_error = ltep_pkg::ST_MONTH;
            end
            field_has_bad = 1'b0;
         end
         5'd7, 5'd8, 5'd9, 5'd10: begin
            if (is_digit(ch)) year_acc = year_acc * 16'd10 + 16'(ch - ltep_pkg::CHAR_ZERO);
            else field_has_bad = 1'b1;
         end
         5'd11, 5'd14, 5'd17: close_field(ch, ltep_pkg::CHAR_COLON);
         5'd12, 5'd13: begin
            if (is_digit(ch)) hour_acc = hour_acc * 8'd10 + (ch - ltep_pkg::CHAR_ZERO);
            else field_has_bad = 1'b1;
         end
         5'd15, 5'd16: begin
            if (is_digit(ch)) minute_acc = minute_acc * 8'd10 + (ch - ltep_pkg::CHAR_ZERO);
            else field_has_bad = 1'b1;
         end
         5'd18, 5'd19: begin
            if (is_digit(ch)) second_acc = second_acc * 8'd10 + (ch - ltep_pkg::CHAR_ZERO);
            else field_has_bad = 1'b1;
         end
         5'd20: close_field(ch, ltep_pkg::CHAR_SPACE);
         5'd21: begin
            zone_plus = (ch == ltep_pkg::CHAR_PLUS);
            if (ch != ltep_pkg::CHAR_PLUS && ch != ltep_pkg::CHAR_MINUS &&
                zone_first_error == ltep_pkg::ST_OK)
               zone_first_error = ltep_pkg::ST_ZONE;
         end
         5'd22, 5'd23: begin
            if (is_digit(ch)) zone_hr = zone_hr * 8'd10 + (ch - ltep_pkg::CHAR_ZERO);
            else if (zone_first_error == ltep_pkg::ST_OK) zone_first_error = ltep_pkg::ST_DIGIT;
         end
         5'd24, 5'd25: begin
            if (is_digit(ch)) zone_min = zone_min * 8'd10 + (ch - ltep_pkg::CHAR_ZERO);
            else if (zone_first_error == ltep_pkg::ST_OK) zone_first_error = ltep_pkg::ST_DIGIT;
         end
         default: ;
      endcase
      if (char_count < 5'(STAMP_LEN + 1)) char_count = char_count + 5'd1;

      if (last) begin
         verdict = first_error;
         if (verdict == ltep_pkg::ST_OK && char_count != 5'(STAMP_LEN))
            verdict = ltep_pkg::ST_LENGTH;
         if (verdict == ltep_pkg::ST_OK) verdict = zone_first_error;
         outcome.status = verdict;
         outcome.epoch_seconds = (verdict == ltep_pkg::ST_OK) ? epoch_from_fields() : 64'd0;
         expected_epochs.push_back(outcome);
         clear_parse_state();
      end
   endfunction

   // predict on every accepted character
   always @(posedge clock) begin
      if (!reset && push && !full) parse_char(req_char_byte, req_last_char);
   end

   // compare a popped result with the oldest expectation
   function automatic void check_result();
      ltep_pkg::result_type want;
      if (expected_epochs.size() == 0) begin
         $error("result with nothing expected: epoch_seconds %0d status %0d",
                rsp_epoch_seconds, rsp_status);
         error_count++;
      end else begin
         want = expected_epochs.pop_front();
         if (rsp_epoch_seconds !== want.epoch_seconds) begin
            $error("epoch_seconds: expected %0d, got %0d",
                   want.epoch_seconds, rsp_epoch_seconds);
            error_count++;
         end
         if (rsp_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_status);
            error_count++;
         end
      end
   endfunction

   // result side: random pops, long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) check_result();
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL log_time_to_epoch_parser");
            $finish;
         end
      end
   end

   // send one item, with random idle cycles ahead of it
   task automatic send_char(input logic [7:0] ch, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_char_byte <= ch;
      req_last_char <= last;
      do @(posedge clock); while (full);
   endtask

   task automatic send_text(input char_list_type text);
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
   endtask

   function automatic logic [7:0] digit_char(input int v);
      return ltep_pkg::CHAR_ZERO + 8'(v % 10);
   endfunction

   // well-formed text from field values
   function automatic char_list_type make_stamp(input int d, input int mon, input int yr,
                                                input int hh, input int mm, input int ss,
                                                input bit plus, input int zh, input int zm);
      char_list_type s;
      s.push_back(digit_char(d / 10));
      s.push_back(digit_char(d));
      s.push_back(ltep_pkg::CHAR_SLASH);
      s.push_back(MONTH_TEXT[mon][23:16]);
      s.push_back(MONTH_TEXT[mon][15:8]);
      s.push_back(MONTH_TEXT[mon][7:0]);
      s.push_back(ltep_pkg::CHAR_SLASH);
      s.push_back(digit_char(yr / 1000));
      s.push_back(digit_char(yr / 100));
      s.push_back(digit_char(yr / 10));
      s.push_back(digit_char(yr));
      s.push_back(ltep_pkg::CHAR_COLON);
      s.push_back(digit_char(hh / 10));
      s.push_back(digit_char(hh));
      s.push_back(ltep_pkg::CHAR_COLON);
      s.push_back(digit_char(mm / 10));
      s.push_back(digit_char(mm));
      s.push_back(ltep_pkg::CHAR_COLON);
      s.push_back(digit_char(ss / 10));
      s.push_back(digit_char(ss));
      s.push_back(ltep_pkg::CHAR_SPACE);
      s.push_back(plus ? ltep_pkg::CHAR_PLUS : ltep_pkg::CHAR_MINUS);
      s.push_back(digit_char(zh / 10));
      s.push_back(digit_char(zh));
      s.push_back(digit_char(zm / 10));
      s.push_back(digit_char(zm));
      return s;
   endfunction

   function automatic char_list_type random_good_stamp();
      int yr;
      bit wide;
      wide = $urandom_range(1);
      case ($urandom_range(3))
         0:       yr = $urandom_range(2038, 1970);
         1:       yr = $urandom_range(2100, 1900);
         2:       yr = $urandom_range(9999, 0);
         default: yr = $urandom_range(1975, 1960);
      endcase
      return make_stamp(wide ? $urandom_range(99) : $urandom_range(31, 1),
                        $urandom_range(11), yr,
                        wide ? $urandom_range(99) : $urandom_range(23),
                        wide ? $urandom_range(99) : $urandom_range(59),
                        wide ? $urandom_range(99) : $urandom_range(59),
                        $urandom_range(1),
                        wide ? $urandom_range(99) : $urandom_range(14),
                        wide ? $urandom_range(99) : $urandom_range(59));
   endfunction

   // characters likely to hit a syntax check
   function automatic logic [7:0] tricky_char();
      case ($urandom_range(6))
         0:       return digit_char($urandom_range(9));
         1:       return ltep_pkg::CHAR_SLASH;
         2:       return ltep_pkg::CHAR_COLON;
         3:       return ltep_pkg::CHAR_SPACE;
         4:       return ltep_pkg::CHAR_PLUS;
         5:       return ltep_pkg::CHAR_MINUS;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // mostly well-formed text, the rest broken or noise
   function automatic char_list_type random_stamp();
      char_list_type s;
      s = random_good_stamp();
      if ($urandom_range(99) < 25) begin
         case ($urandom_range(4))
            0: s[$urandom_range(STAMP_LEN - 1)] = tricky_char();
            1: s = s[0:$urandom_range(STAMP_LEN - 2)];
            2: repeat ($urandom_range(6, 1)) s.push_back(tricky_char());
            3: s[$urandom_range(5, 3)] ^= 8'h20;
            default: begin
               s.delete();
               repeat ($urandom_range(40, 1)) s.push_back(8'($urandom_range(255)));
            end
         endcase
      end
      return s;
   endfunction

   // well-formed values at the edges of the calendar and the fields
   task automatic test_directed_values();
      send_text(make_stamp(1, 0, 1970, 0, 0, 0, 1, 0, 0));
      send_text(make_stamp(99, 11, 9999, 99, 99, 99, 0, 99, 99));
      send_text(make_stamp(0, 0, 1970, 0, 0, 0, 1, 0, 0));
      send_text(make_stamp(1, 0, 1970, 0, 0, 0, 1, 1, 30));
      send_text(make_stamp(31, 11, 1969, 23, 59, 59, 0, 0, 0));
      send_text(make_stamp(15, 5, 0, 12, 0, 0, 1, 0, 0));
      send_text(make_stamp(29, 1, 2000, 12, 0, 0, 1, 0, 0));
      send_text(make_stamp(1, 2, 2000, 0, 0, 0, 1, 0, 0));
      send_text(make_stamp(1, 2, 1900, 0, 0, 0, 1, 0, 0));
      send_text(make_stamp(1, 2, 2024, 0, 0, 0, 0, 0, 0));
      send_text(make_stamp(1, 2, 2023, 0, 0, 0, 0, 0, 0));
      send_text(make_stamp(10, 9, 2000, 13, 55, 36, 0, 7, 0));
      // one of each month
      for (int m = 0; m < 12; m++) begin
         send_text(make_stamp($urandom_range(28, 1), m, $urandom_range(2099, 1970),
                              $urandom_range(23), $urandom_range(59),
                              $urandom_range(59), $urandom_range(1),
                              $urandom_range(12), $urandom_range(59)));
      end
   endtask

   // each format error, their order and wrong lengths
   task automatic test_directed_errors();
      char_list_type base;
      char_list_type s;
      base = make_stamp(10, 9, 2000, 13, 55, 36, 0, 7, 0);
      // each separator replaced
      foreach (SEPARATOR_POS[i]) begin
         s = base;
         s[SEPARATOR_POS[i]] = ltep_pkg::CHAR_PLUS;
         send_text(s);
      end
      // month lower case, month unknown
      s = base; s[3] = "o";
      send_text(s);
      s = base; s[5] = "x";
      send_text(s);
      // a non-digit in each numeric field
      s = base; s[1] = "a";
      send_text(s);
      s = base; s[9] = ltep_pkg::CHAR_SLASH;
      send_text(s);
      s = base; s[12] = ltep_pkg::CHAR_SPACE;
      send_text(s);
      s = base; s[16] = 8'hFF;
      send_text(s);
      s = base; s[18] = 8'h00;
      send_text(s);
      // zone sign, zone digit, both
      s = base; s[21] = "*";
      send_text(s);
      s = base; s[24] = "Z";
      send_text(s);
      s = base; s[21] = ltep_pkg::CHAR_SPACE; s[23] = "q";
      send_text(s);
      // bad digit and bad separator in one field, then an earlier field first
      s = base; s[0] = "x"; s[2] = ltep_pkg::CHAR_COLON;
      send_text(s);
      s = base; s[0] = "x"; s[6] = ltep_pkg::CHAR_COLON;
      send_text(s);
      // short, long, short after an earlier error
      send_text(base[0:9]);
      send_text(base[0:0]);
      send_text(base[0:24]);
      s = base; s.push_back(digit_char(1));
      send_text(s);
      s = base; repeat (4) s.push_back(8'($urandom_range(255)));
      send_text(s);
      s = base; s[3] = "j";
      send_text(s[0:14]);
   endtask

   task automatic test_random_traffic();
      repeat (RANDOM_STAMPS) send_text(random_stamp());
   endtask

   // results held back while text keeps coming, so the input stalls
   task automatic test_backpressure();
      hold_request = 1'b1;
      repeat (PRESSURE_STAMPS) send_text(random_good_stamp());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender mostly busy, receiver mostly idle
      send_idle_pct = 9;
      rsp_idle_pct = 86;
      test_directed_values();
      test_directed_errors();
      test_random_traffic();

      // sender mostly idle, receiver mostly busy
      send_idle_pct = 86;
      rsp_idle_pct = 9;
      test_random_traffic();

      // no idling on either side
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      test_backpressure();
      test_random_traffic();

      push <= 1'b0;
      while (expected_epochs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS log_time_to_epoch_parser");
      end else begin
         $display("FAIL log_time_to_epoch_parser");
      end
      $finish;
   end

endmodule
